// ----- rtl/bbss_pkg.sv -----
package bbss_pkg;

    localparam int CELL_FIELDS = 4;

    localparam logic [7:0] STATUS_FAST_CHARGE = 8'h40;
    localparam logic [7:0] STATUS_CHARGE      = 8'h80;
    localparam logic [7:0] FIRST_POLL_SECONDS = 8'd5;
    localparam logic [6:0] PERCENT_MAX        = 7'd100;

    typedef enum logic [1:0] {
        MSG_NONE     = 2'd0,
        MSG_WARN     = 2'd1,
        MSG_BATTERY  = 2'd2,
        MSG_RESTORED = 2'd3
    } t_msg;

    typedef enum logic [2:0] {
        CFG_LOW_CELL_MV   = 3'd0,
        CFG_SHUTDOWN_SECS = 3'd1,
        CFG_ALERT_SECS    = 3'd2,
        CFG_POLL_NORMAL   = 3'd3,
        CFG_POLL_LOW      = 3'd4
    } t_cfg_idx;

    // Classified item as passed from the front end to the back end
    typedef struct packed {
        logic       tick;
        logic       charging;
        logic       cell_low;
        logic [6:0] percent;
    } t_item;

    typedef struct packed {
        t_msg       kind;
        logic [6:0] percent;
        logic [7:0] display_secs;
        logic       cancel;
        logic [7:0] poll_secs;
        logic       cell_low;
        logic       power_off;
        logic [7:0] secs_left;
        logic       last;
    } t_result;

endpackage

// ----- rtl/battery_backup_shutdown_supervisor_top.sv -----
// Channel   Handshake                     Payload
// -------   ---------------------------   ----------------------------------------
// input     i_in_valid / o_in_stall       i_opcode, i_status_byte, i_cell_*_mv,
//                                         i_charge_percent
// output    o_out_valid / i_out_stall     o_message_kind ... o_last
// config    i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One item per cycle enters a two-entry queue while it is not full; the back end emits one
// result per cycle while the output is not stalled, a second result of a sample waiting in a pending register.
// An accepted item is registered in the queue and then in the output register.
// Synchronous active-low reset clears the control state and loads the register defaults.
// Input stalls only when the queue is full; the output register holds while stalled.
module battery_backup_shutdown_supervisor_top
    import bbss_pkg::*;
#(
    parameter int NUM_CELLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_status_byte,
    input  logic [15:0] i_cell_a_mv,
    input  logic [15:0] i_cell_b_mv,
    input  logic [15:0] i_cell_c_mv,
    input  logic [15:0] i_cell_d_mv,
    input  logic [6:0]  i_charge_percent,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_message_kind,
    output logic [6:0]  o_message_percent,
    output logic [7:0]  o_display_seconds,
    output logic        o_cancel_display,
    output logic [7:0]  o_next_poll_seconds,
    output logic        o_cell_low,
    output logic        o_power_off,
    output logic [7:0]  o_seconds_left,
    output logic        o_last
);

    logic [15:0] r_low_cell_mv;
    logic [7:0]  r_shutdown_secs;
    logic [7:0]  r_alert_secs;
    logic [7:0]  r_poll_normal;
    logic [7:0]  r_poll_low;

    t_item       item;
    t_item       q_data;
    logic        q_full;
    logic        q_vld;
    logic        q_pop;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cell_mv   <= 16'd3150;
            r_shutdown_secs <= 8'd30;
            r_alert_secs    <= 8'd5;
            r_poll_normal   <= 8'd60;
            r_poll_low      <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_CELL_MV:   r_low_cell_mv   <= i_cfg_data;
                CFG_SHUTDOWN_SECS: r_shutdown_secs <= i_cfg_data[7:0];
                CFG_ALERT_SECS:    r_alert_secs    <= i_cfg_data[7:0];
                CFG_POLL_NORMAL:   r_poll_normal   <= i_cfg_data[7:0];
                CFG_POLL_LOW:      r_poll_low      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bbss_front #(
        .NUM_CELLS(NUM_CELLS)
    ) u_front (
        .i_opcode        (i_opcode),
        .i_status_byte   (i_status_byte),
        .i_cell_a_mv     (i_cell_a_mv),
        .i_cell_b_mv     (i_cell_b_mv),
        .i_cell_c_mv     (i_cell_c_mv),
        .i_cell_d_mv     (i_cell_d_mv),
        .i_charge_percent(i_charge_percent),
        .i_low_cell_mv   (r_low_cell_mv),
        .o_item          (item)
    );

    assign o_in_stall = q_full;

    bbss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_in_valid && !q_full),
        .i_data (item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_vld  (q_vld),
        .o_data (q_data)
    );

    bbss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_vld        (q_vld),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .i_shutdown_secs(r_shutdown_secs),
        .i_alert_secs   (r_alert_secs),
        .i_poll_normal  (r_poll_normal),
        .i_poll_low     (r_poll_low),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result       (result)
    );

    assign o_message_kind      = result.kind;
    assign o_message_percent   = result.percent;
    assign o_display_seconds   = result.display_secs;
    assign o_cancel_display    = result.cancel;
    assign o_next_poll_seconds = result.poll_secs;
    assign o_cell_low          = result.cell_low;
    assign o_power_off         = result.power_off;
    assign o_seconds_left      = result.secs_left;
    assign o_last              = result.last;

endmodule

// ----- rtl/bbss_front.sv -----
module bbss_front
    import bbss_pkg::*;
#(
    parameter int NUM_CELLS = 4
) (
    input  logic        i_opcode,
    input  logic [7:0]  i_status_byte,
    input  logic [15:0] i_cell_a_mv,
    input  logic [15:0] i_cell_b_mv,
    input  logic [15:0] i_cell_c_mv,
    input  logic [15:0] i_cell_d_mv,
    input  logic [6:0]  i_charge_percent,
    input  logic [15:0] i_low_cell_mv,
    output t_item       o_item
);

    logic [15:0] cells [CELL_FIELDS];
    logic        any_low;

    assign cells[0] = i_cell_a_mv;
    assign cells[1] = i_cell_b_mv;
    assign cells[2] = i_cell_c_mv;
    assign cells[3] = i_cell_d_mv;

    // only the first NUM_CELLS fields are populated cells
    always_comb begin
        any_low = 1'b0;
        for (int i = 0; i < CELL_FIELDS; i++) begin
            if (i < NUM_CELLS && cells[i] < i_low_cell_mv) begin
                any_low = 1'b1;
            end
        end
    end

    always_comb begin
        o_item.tick     = i_opcode;
        o_item.charging = |(i_status_byte & (STATUS_FAST_CHARGE | STATUS_CHARGE));
        o_item.cell_low = any_low;
        o_item.percent  = (i_charge_percent > PERCENT_MAX) ? PERCENT_MAX : i_charge_percent;
    end

endmodule

// ----- rtl/bbss_queue.sv -----
module bbss_queue
    import bbss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_vld,
    output t_item o_data
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full = (r_count == 2'd2);
    assign o_vld  = (r_count != 2'd0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/bbss_back.sv -----
module bbss_back
    import bbss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_vld,
    input  t_item      i_q_data,
    output logic       o_q_pop,
    input  logic [7:0] i_shutdown_secs,
    input  logic [7:0] i_alert_secs,
    input  logic [7:0] i_poll_normal,
    input  logic [7:0] i_poll_low,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_result
);

    logic       r_first;
    logic       r_on_batt;
    logic       r_armed;
    logic [7:0] r_count;
    logic       n_first;
    logic       n_on_batt;
    logic       n_armed;
    logic [7:0] n_count;

    t_result    r_out;
    logic       r_out_vld;
    t_result    r_pend;
    logic       r_pend_vld;

    t_result    res0;
    t_result    res1;
    logic       two;

    t_msg       kind1;
    logic       cancel1;
    logic       warn;
    logic [7:0] sd_len;
    logic [7:0] poll;
    logic       can_load;

    assign can_load = !r_out_vld || !i_out_stall;
    assign o_q_pop  = can_load && !r_pend_vld && i_q_vld;

    always_comb begin
        n_first   = r_first;
        n_on_batt = r_on_batt;
        n_armed   = r_armed;
        n_count   = r_count;
        res0      = '0;
        res1      = '0;
        two       = 1'b0;
        kind1     = MSG_NONE;
        cancel1   = 1'b0;
        warn      = 1'b0;
        sd_len    = (i_shutdown_secs == 8'd0) ? 8'd1 : i_shutdown_secs;
        poll      = i_q_data.cell_low ? i_poll_low : i_poll_normal;

        if (i_q_data.tick) begin
            // armed with zero left means already expired: no second power-off
            if (r_armed && r_count != 8'd0) begin
                n_count        = r_count - 8'd1;
                res0.power_off = (r_count == 8'd1);
            end
            res0.secs_left = n_count;
            res0.last      = 1'b1;
        end else if (r_first) begin
            n_on_batt      = !i_q_data.charging;
            n_first        = 1'b0;
            res0.poll_secs = FIRST_POLL_SECONDS;
            res0.secs_left = r_count;
            res0.last      = 1'b1;
        end else begin
            if (!i_q_data.charging && !r_on_batt) begin
                kind1     = MSG_BATTERY;
                n_on_batt = 1'b1;
            end else if (r_on_batt && i_q_data.charging) begin
                if (r_armed) begin
                    n_armed = 1'b0;
                    n_count = 8'd0;
                    cancel1 = 1'b1;
                end
                kind1     = MSG_RESTORED;
                n_on_batt = 1'b0;
            end

            if (i_q_data.cell_low && !i_q_data.charging && !n_armed) begin
                n_count = sd_len;
                n_armed = 1'b1;
                warn    = 1'b1;
            end

            res0.kind         = kind1;
            res0.percent      = (kind1 == MSG_NONE) ? 7'd0 : i_q_data.percent;
            res0.display_secs = (kind1 == MSG_NONE) ? 8'd0 : i_alert_secs;
            res0.cancel       = cancel1;
            res0.poll_secs    = poll;
            res0.cell_low     = i_q_data.cell_low;
            res0.secs_left    = n_count;
            res0.last         = !warn;

            res1.kind         = MSG_WARN;
            res1.percent      = i_q_data.percent;
            res1.display_secs = sd_len;
            res1.poll_secs    = poll;
            res1.cell_low     = 1'b1;
            res1.secs_left    = n_count;
            res1.last         = 1'b1;

            if (warn) begin
                if (kind1 == MSG_NONE) begin
                    res0 = res1;
                end else begin
                    two = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_on_batt  <= 1'b0;
            r_armed    <= 1'b0;
            r_count    <= 8'd0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_first   <= n_first;
                r_on_batt <= n_on_batt;
                r_armed   <= n_armed;
                r_count   <= n_count;
            end
            if (can_load) begin
                if (r_pend_vld) begin
                    r_out_vld  <= 1'b1;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_out_vld  <= i_q_vld;
                    r_pend_vld <= i_q_vld && two;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_pend_vld) begin
                r_out <= r_pend;
            end else if (i_q_vld) begin
                r_out  <= res0;
                r_pend <= res1;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

// ----- tb/battery_backup_shutdown_supervisor_top_tb.sv -----
module battery_backup_shutdown_supervisor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbss_pkg::*;

    localparam int          NUM_CELLS        = 4;
    localparam int          RANDOM_PHASES    = 8;
    localparam int          ITEMS_PER_PHASE  = 94;
    localparam int          PRESSURE_PHASE   = 2;
    localparam int          HOLD_OFF_CYCLES  = 40;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          IDLE_LIMIT       = 1000;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [15:0] CELL_FULL        = 16'hFFFF;

    typedef struct packed {
        logic [15:0] low_mv;
        logic [7:0]  shutdown;
        logic [7:0]  alert;
        logic [7:0]  poll_normal;
        logic [7:0]  poll_low;
    } t_settings;

    typedef struct packed {
        logic                         opcode;
        logic [7:0]                   status;
        logic [CELL_FIELDS-1:0][15:0] cells;
        logic [6:0]                   percent;
    } t_sample;

    // Tracks the supervisor state and queues the results each transaction should cause
    class shutdown_scoreboard;
        t_settings  regs;
        bit         awaiting_first;
        bit         on_battery;
        bit         armed;
        logic [7:0] countdown;
        t_result    expected_q[$];
        int         items, ticks, results, warnings, aborts, power_offs, mismatches;

        function new();
            regs           = '{16'd3150, 8'd30, 8'd5, 8'd60, 8'd10};
            awaiting_first = 1'b1;
            on_battery     = 1'b0;
            armed          = 1'b0;
            countdown      = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(t_result r);
            expected_q = {expected_q, r};
        endfunction

        function t_result compose(t_msg kind, logic [6:0] pct, logic [7:0] disp, logic cancel,
                                  logic [7:0] poll, logic low, logic poff, logic last);
            t_result r;
            r.kind         = kind;
            r.percent      = (kind == MSG_NONE) ? 7'd0 : pct;
            r.display_secs = (kind == MSG_NONE) ? 8'd0 : disp;
            r.cancel       = cancel;
            r.poll_secs    = poll;
            r.cell_low     = low;
            r.power_off    = poff;
            r.secs_left    = countdown;
            r.last         = last;
            return r;
        endfunction

        function void note_item(t_sample s);
            logic [6:0] pct;
            logic [7:0] sd_len;
            logic [7:0] poll;
            bit         charging, low, warn, cancel, poff;
            t_msg       kind;
            items++;
            if (s.opcode) begin
                ticks++;
                poff = 1'b0;
                if (armed && countdown != 8'd0) begin
                    countdown = countdown - 8'd1;
                    poff      = (countdown == 8'd0);
                end
                power_offs += poff;
                add_expected(compose(MSG_NONE, '0, '0, 1'b0, '0, 1'b0, poff, 1'b1));
                return;
            end
            pct      = (s.percent > PERCENT_MAX) ? PERCENT_MAX : s.percent;
            charging = |(s.status & (STATUS_FAST_CHARGE | STATUS_CHARGE));
            if (awaiting_first) begin
                on_battery     = !charging;
                awaiting_first = 1'b0;
                add_expected(compose(MSG_NONE, '0, '0, 1'b0, FIRST_POLL_SECONDS,
                                     1'b0, 1'b0, 1'b1));
                return;
            end
            kind   = MSG_NONE;
            cancel = 1'b0;
            if (!charging && !on_battery) begin
                kind       = MSG_BATTERY;
                on_battery = 1'b1;
            end else if (on_battery && charging) begin
                // mains back: abort any pending shutdown
                if (armed) begin
                    armed     = 1'b0;
                    countdown = '0;
                    cancel    = 1'b1;
                    aborts++;
                end
                kind       = MSG_RESTORED;
                on_battery = 1'b0;
            end
            low = 1'b0;
            for (int c = 0; c < NUM_CELLS && c < CELL_FIELDS; c++)
                if (s.cells[c] < regs.low_mv) low = 1'b1;
            sd_len = (regs.shutdown == 8'd0) ? 8'd1 : regs.shutdown;
            // an expired countdown stays armed, so no re-arm until mains returns
            warn = low && !charging && !armed;
            if (warn) begin
                countdown = sd_len;
                armed     = 1'b1;
                warnings++;
            end
            poll = low ? regs.poll_low : regs.poll_normal;
            if (kind != MSG_NONE || !warn)
                add_expected(compose(kind, pct, regs.alert, cancel, poll, low, 1'b0, !warn));
            if (warn)
                add_expected(compose(MSG_WARN, pct, sd_len, 1'b0, poll, 1'b1, 1'b0, 1'b1));
        endfunction

        function string show(t_result r);
            return {$sformatf("kind=%s pct=%0d disp=%0d cancel=%0b ",
                              r.kind.name(), r.percent, r.display_secs, r.cancel),
                    $sformatf("poll=%0d low=%0b poff=%0b left=%0d last=%0b",
                              r.poll_secs, r.cell_low, r.power_off, r.secs_left, r.last)};
        endfunction

        function void check_result(t_result got);
            t_result want;
            results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result at %0t: %s", $time, show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d wrong at %0t", results, $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [7:0]  i_status_byte;
    logic [15:0] i_cell_a_mv;
    logic [15:0] i_cell_b_mv;
    logic [15:0] i_cell_c_mv;
    logic [15:0] i_cell_d_mv;
    logic [6:0]  i_charge_percent;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_message_kind;
    logic [6:0]  o_message_percent;
    logic [7:0]  o_display_seconds;
    logic        o_cancel_display;
    logic [7:0]  o_next_poll_seconds;
    logic        o_cell_low;
    logic        o_power_off;
    logic [7:0]  o_seconds_left;
    logic        o_last;

    shutdown_scoreboard sb;
    t_sample            tx_item = '0;
    bit                 tx_quiet;
    bit                 rx_quiet;
    int                 hold_off_cycles;
    bit                 mains_up;
    int                 idle_cycles;
    int                 settings_loaded;

    assign i_opcode         = tx_item.opcode;
    assign i_status_byte    = tx_item.status;
    assign i_cell_a_mv      = tx_item.cells[0];
    assign i_cell_b_mv      = tx_item.cells[1];
    assign i_cell_c_mv      = tx_item.cells[2];
    assign i_cell_d_mv      = tx_item.cells[3];
    assign i_charge_percent = tx_item.percent;

    battery_backup_shutdown_supervisor_top #(
        .NUM_CELLS(NUM_CELLS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_status_byte      (i_status_byte),
        .i_cell_a_mv        (i_cell_a_mv),
        .i_cell_b_mv        (i_cell_b_mv),
        .i_cell_c_mv        (i_cell_c_mv),
        .i_cell_d_mv        (i_cell_d_mv),
        .i_charge_percent   (i_charge_percent),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_message_kind     (o_message_kind),
        .o_message_percent  (o_message_percent),
        .o_display_seconds  (o_display_seconds),
        .o_cancel_display   (o_cancel_display),
        .o_next_poll_seconds(o_next_poll_seconds),
        .o_cell_low         (o_cell_low),
        .o_power_off        (o_power_off),
        .o_seconds_left     (o_seconds_left),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sample tick_of();
        t_sample t;
        t.opcode  = 1'b1;
        t.status  = 8'($urandom);
        t.cells   = {$urandom, $urandom};
        t.percent = 7'($urandom);
        return t;
    endfunction

    function automatic t_sample sample_of(logic [7:0] st, logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c, logic [15:0] d, logic [6:0] pct);
        t_sample t;
        t.opcode  = 1'b0;
        t.status  = st;
        t.cells   = {d, c, b, a};
        t.percent = pct;
        return t;
    endfunction

    // Mains state drifts slowly; cell voltages are mostly at or above the threshold, sometimes just below it
    function automatic t_sample random_item(logic [15:0] thr);
        t_sample t;
        if ($urandom_range(0, 99) < 40) return tick_of();
        if ($urandom_range(0, 7) == 0) mains_up = !mains_up;
        t.opcode = 1'b0;
        t.status = 8'($urandom);
        if (!mains_up)
            t.status[7:6] = 2'b00;
        else if (t.status[7:6] == 2'b00)
            t.status[7:6] = 2'($urandom_range(1, 3));
        for (int c = 0; c < CELL_FIELDS; c++) begin
            case ($urandom_range(0, 7))
                0:       t.cells[c] = thr - 16'd1;
                1:       t.cells[c] = thr;
                2:       t.cells[c] = 16'($urandom);
                default: t.cells[c] = 16'($urandom_range(65535, int'(thr)));
            endcase
        end
        t.percent = 7'($urandom_range(0, 127));
        return t;
    endfunction

    function automatic t_settings draw_settings(int p);
        t_settings s;
        if (p == 0) return '{16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255};
        if (p == 1) return '{16'd1, 8'd1, 8'd1, 8'd1, 8'd1};
        s.low_mv      = 16'($urandom_range(2800, 3600));
        s.shutdown    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(13, 255))
                                                    : 8'($urandom_range(1, 12));
        s.alert       = 8'($urandom_range(1, 255));
        s.poll_normal = 8'($urandom_range(1, 255));
        s.poll_low    = 8'($urandom_range(1, 255));
        return s;
    endfunction

    task automatic send_item(t_sample it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tx_item    <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // 8-bit registers get random upper data bits, which must be ignored
    task automatic load_settings(t_settings s);
        t_cfg_idx idx;
        idx = idx.first();
        repeat (idx.num()) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            case (idx)
                CFG_LOW_CELL_MV:   i_cfg_data <= s.low_mv;
                CFG_SHUTDOWN_SECS: i_cfg_data <= {8'($urandom), s.shutdown};
                CFG_ALERT_SECS:    i_cfg_data <= {8'($urandom), s.alert};
                CFG_POLL_NORMAL:   i_cfg_data <= {8'($urandom), s.poll_normal};
                CFG_POLL_LOW:      i_cfg_data <= {8'($urandom), s.poll_low};
                default:           i_cfg_data <= '0;
            endcase
            @(negedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        sb.regs = s;
        settings_loaded++;
    endtask

    always @(posedge i_clk) begin : bus_monitor
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_item(tx_item);
            if (o_out_valid && !i_out_stall) begin
                got = '{kind: t_msg'(o_message_kind), percent: o_message_percent,
                        display_secs: o_display_seconds, cancel: o_cancel_display,
                        poll_secs: o_next_poll_seconds, cell_low: o_cell_low,
                        power_off: o_power_off, secs_left: o_seconds_left, last: o_last};
                sb.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            n = rx_quiet ? 0 : $urandom_range(0, 9);
            if (hold_off_cycles > 0) begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_settings s;
        sb         = new();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LOW_CELL_MV;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: first sample, alerts, warning, abort, double result, threshold edge
        send_item(tick_of());
        send_item(sample_of(8'hC0, CELL_FULL, CELL_FULL, CELL_FULL, CELL_FULL, 7'd100));
        send_item(sample_of(8'h3F, CELL_FULL, CELL_FULL, CELL_FULL, CELL_FULL, 7'd127));
        send_item(sample_of(8'h00, 16'd0, CELL_FULL, CELL_FULL, CELL_FULL, 7'd0));
        send_item(tick_of());
        send_item(tick_of());
        send_item(sample_of(8'h80, 16'd0, 16'd0, 16'd0, 16'd0, 7'd55));
        send_item(sample_of(8'h00, CELL_FULL, CELL_FULL, CELL_FULL, 16'd3149, 7'd101));
        send_item(sample_of(8'h00, CELL_FULL, 16'd3150, CELL_FULL, CELL_FULL, 7'd1));

        // zero countdown length acts as one second; zero alert and poll times pass through
        settle();
        load_settings('{16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0});
        send_item(sample_of(8'h40, CELL_FULL, CELL_FULL, CELL_FULL, CELL_FULL, 7'd64));
        send_item(sample_of(8'h00, CELL_FULL, CELL_FULL, 16'hFFFE, CELL_FULL, 7'd99));
        send_item(tick_of());
        send_item(tick_of());
        send_item(sample_of(8'h00, CELL_FULL, 16'd0, CELL_FULL, CELL_FULL, 7'd50));
        send_item(sample_of(8'hC0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd127));

        // threshold of zero: nothing can be low
        settle();
        load_settings('{16'd0, 8'd255, 8'd255, 8'd255, 8'd255});
        send_item(sample_of(8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 7'd100));
        send_item(sample_of(8'h3F, 16'd0, 16'd0, 16'd0, 16'd0, 7'd101));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            s = draw_settings(p);
            load_settings(s);
            tx_quiet = (p % 3 == 2);
            rx_quiet = (p % 4 == 3);
            if (p == PRESSURE_PHASE) hold_off_cycles = HOLD_OFF_CYCLES;
            repeat (ITEMS_PER_PHASE) send_item(random_item(s.low_mv));
        end
        settle();

        $display("covered %0d transactions in (%0d ticks), %0d results, %0d register settings",
                 sb.items, sb.ticks, sb.results, settings_loaded);
        $display("shutdown warnings %0d, aborts %0d, power-offs %0d, wrong results %0d",
                 sb.warnings, sb.aborts, sb.power_offs, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
